// ===== src/rtf_pkg.sv =====
`default_nettype none
package rtf_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 9;
  localparam int ADDR_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int HDR_IDX_W = 5;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;

  // start byte, two length bytes, then the 14 header bytes
  localparam int HDR_BEATS = 17;
  // header bytes from this position on enter the checksum
  localparam logic [HDR_IDX_W-1:0] SUM_FIRST_IDX = 5'd3;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] API_TYPE   = 8'h10;
  localparam logic [BYTE_W-1:0] FRAME_ID   = 8'h00;
  localparam logic [BYTE_W-1:0] NET_ADDR_H = 8'hFF;
  localparam logic [BYTE_W-1:0] NET_ADDR_L = 8'hFE;
  localparam logic [BYTE_W-1:0] OPT_BYTE   = 8'h00;
  localparam logic [BYTE_W-1:0] CSUM_BASE  = 8'hFF;
  localparam logic [15:0]       HDR_LEN    = 16'd14;

  localparam logic [ADDR_W-1:0] DEST_HIGH_RST = 32'h0013A200;
  localparam logic [ADDR_W-1:0] DEST_LOW_RST  = 32'h42839F27;

  localparam logic [CFG_IDX_W-1:0] REG_DEST_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_LOW  = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              last;
    logic [LEN_W-1:0]  len;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  function automatic logic [BYTE_W-1:0] hdr_byte(
    input logic [HDR_IDX_W-1:0] idx,
    input logic [15:0]          flen,
    input logic [ADDR_W-1:0]    hi,
    input logic [ADDR_W-1:0]    lo
  );
    logic [BYTE_W-1:0] b;
    case (idx)
      5'd0:    b = START_BYTE;
      5'd1:    b = flen[15:8];
      5'd2:    b = flen[7:0];
      5'd3:    b = API_TYPE;
      5'd4:    b = FRAME_ID;
      5'd5:    b = hi[31:24];
      5'd6:    b = hi[23:16];
      5'd7:    b = hi[15:8];
      5'd8:    b = hi[7:0];
      5'd9:    b = lo[31:24];
      5'd10:   b = lo[23:16];
      5'd11:   b = lo[15:8];
      5'd12:   b = lo[7:0];
      5'd13:   b = NET_ADDR_H;
      5'd14:   b = NET_ADDR_L;
      default: b = OPT_BYTE;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== src/rtf_front.sv =====
`default_nettype none
module rtf_front #(
  parameter int MAX_PAYLOAD = 256
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [7:0]                in_payload_byte,
  input  wire logic [8:0]                in_payload_length,
  input  wire logic                      q_full,
  output logic                           q_push,
  output rtf_pkg::q_entry_t              q_wdata
);
  import rtf_pkg::*;

  logic             in_frame_r;
  logic [LEN_W-1:0] rem_r;
  logic [LEN_W-1:0] len_sat;
  logic [LEN_W-1:0] rem_cur;
  logic [LEN_W-1:0] rem_nxt;
  logic             first;
  logic             last;

  always_comb begin
    if (in_payload_length == '0) begin
      len_sat = LEN_W'(1);
    end else if ({8'b0, in_payload_length} > 17'(MAX_PAYLOAD)) begin
      len_sat = LEN_W'(MAX_PAYLOAD);
    end else begin
      len_sat = in_payload_length;
    end
    first   = !in_frame_r;
    rem_cur = first ? len_sat : rem_r;
    rem_nxt = rem_cur - LEN_W'(1);
    last    = (rem_nxt == '0);
  end

  assign in_stall      = q_full;
  assign q_push        = in_valid && !q_full;
  assign q_wdata.data  = in_payload_byte;
  assign q_wdata.first = first;
  assign q_wdata.last  = last;
  assign q_wdata.len   = len_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      rem_r      <= '0;
    end else if (q_push) begin
      in_frame_r <= !last;
      rem_r      <= rem_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/rtf_queue.sv =====
`default_nettype none
module rtf_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire rtf_pkg::q_entry_t wdata,
  output logic                   full,
  output rtf_pkg::q_head_t       head,
  input  wire logic              pop
);
  import rtf_pkg::*;

  q_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full        = (cnt_r == QCNT_W'(QDEPTH));
  assign head.valid  = (cnt_r != '0);
  assign head.entry  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/rtf_back.sv =====
`default_nettype none
module rtf_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire rtf_pkg::q_head_t      head,
  output logic                       pop,
  input  wire logic [31:0]           dest_high,
  input  wire logic [31:0]           dest_low,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_byte,
  output logic                       out_end_of_frame
);
  import rtf_pkg::*;

  typedef enum logic [1:0] {ST_HEAD, ST_BODY, ST_CSUM} state_t;

  state_t                st_r, st_nxt;
  logic [HDR_IDX_W-1:0]  idx_r, idx_nxt;
  logic [BYTE_W-1:0]     sum_r, sum_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]     out_byte_r, out_byte_nxt;
  logic                  out_eof_r, out_eof_nxt;
  logic                  adv;
  logic [15:0]           flen;
  logic [BYTE_W-1:0]     hbyte;

  assign adv   = !out_valid_r || !out_stall;
  assign flen  = 16'(head.entry.len) + HDR_LEN;
  assign hbyte = hdr_byte(idx_r, flen, dest_high, dest_low);

  always_comb begin
    st_nxt        = st_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_eof_nxt   = out_eof_r;
    pop           = 1'b0;
    if (adv) begin
      out_valid_nxt = head.valid;
      if (head.valid) begin
        unique case (st_r)
          ST_HEAD: begin
            if (head.entry.first) begin
              out_byte_nxt = hbyte;
              out_eof_nxt  = 1'b0;
              if (idx_r >= SUM_FIRST_IDX) begin
                sum_nxt = sum_r + hbyte;
              end else begin
                sum_nxt = '0;
              end
              idx_nxt = idx_r + HDR_IDX_W'(1);
              if (idx_r == HDR_IDX_W'(HDR_BEATS - 1)) begin
                st_nxt = ST_BODY;
              end
            end else begin
              out_byte_nxt = head.entry.data;
              out_eof_nxt  = 1'b0;
              sum_nxt      = sum_r + head.entry.data;
              if (head.entry.last) begin
                st_nxt = ST_CSUM;
              end else begin
                pop = 1'b1;
              end
            end
          end
          ST_BODY: begin
            out_byte_nxt = head.entry.data;
            out_eof_nxt  = 1'b0;
            sum_nxt      = sum_r + head.entry.data;
            if (head.entry.last) begin
              st_nxt = ST_CSUM;
            end else begin
              pop     = 1'b1;
              st_nxt  = ST_HEAD;
              idx_nxt = '0;
            end
          end
          ST_CSUM: begin
            out_byte_nxt = CSUM_BASE - sum_r;
            out_eof_nxt  = 1'b1;
            sum_nxt      = '0;
            pop          = 1'b1;
            st_nxt       = ST_HEAD;
            idx_nxt      = '0;
          end
          default: st_nxt = ST_HEAD;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_HEAD;
      idx_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      idx_r       <= idx_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_byte_r <= out_byte_nxt;
    out_eof_r  <= out_eof_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_end_of_frame = out_eof_r;

endmodule
`default_nettype wire

// ===== src/radio_api_transmit_framer.sv =====
// Transmit-request framer: turns a stream of payload bytes into API frames.
// Input channel (in_valid / in_stall): one payload byte per beat; the
// payload length is sampled on the first byte of each frame only.
// Output channel (out_valid / out_stall): one frame byte per beat, with
// out_end_of_frame set on the closing checksum byte.
// Config channel (cfg_valid / cfg_ready): cfg_index 0 writes the upper and
// 1 the lower half of the destination address; cfg_ready is always high.
// Write it only while no frame is in flight.
// An accepted input byte passes through the queue and the output register.
// Throughput is one output byte per cycle while out_stall is low: a first
// byte yields the start, length and header bytes, then itself; a middle
// byte, itself; a last byte, itself and the checksum. A two-entry queue
// sits between input classifier and serializer, so input keeps flowing
// while the output stalls, until the queue is full; in_stall shows full.
// Reset clears the frame state, the queue and the output valid flag, and
// restores the default destination address.
`default_nettype none
module radio_api_transmit_framer #(
  parameter int MAX_PAYLOAD = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    in_payload_byte,
  input  wire logic [8:0]                    in_payload_length,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         out_byte,
  output logic                               out_end_of_frame,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rtf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_wdata
);
  import rtf_pkg::*;

  logic [ADDR_W-1:0] dest_high_r;
  logic [ADDR_W-1:0] dest_low_r;
  logic              q_full;
  logic              q_push;
  q_entry_t          q_wdata;
  q_head_t           q_head;
  logic              q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_high_r <= DEST_HIGH_RST;
      dest_low_r  <= DEST_LOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEST_HIGH: dest_high_r <= cfg_wdata;
        REG_DEST_LOW:  dest_low_r  <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  rtf_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_payload_byte  (in_payload_byte),
    .in_payload_length(in_payload_length),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_wdata          (q_wdata)
  );

  rtf_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .head (q_head),
    .pop  (q_pop)
  );

  rtf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .pop             (q_pop),
    .dest_high       (dest_high_r),
    .dest_low        (dest_low_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_end_of_frame(out_end_of_frame)
  );

endmodule
`default_nettype wire

// ===== src/rtf_checker.sv =====
`default_nettype none
module rtf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       out_end_of_frame
);
  import rtf_pkg::*;

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_byte) && $stable(out_end_of_frame))
    else $error("output beat changed while stalled");

  // after a checksum beat the next beat opens a new frame
  a_start_after_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_end_of_frame |=>
      !out_valid || (out_byte == START_BYTE && !out_end_of_frame))
    else $error("frame after checksum does not begin with start byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind radio_api_transmit_framer rtf_checker u_rtf_checker (.*);
`default_nettype wire
